// File: hw/rtl/bcdq_pkg.sv
// Shared constants for the bounded circular deque: defaults, request modes and status codes.
package bcdq_pkg;

    // Default sizes of the ring store.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Width of the request mode field.
    localparam int MODE_W = 4;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_POP_BACK    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE_AT   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE_VAL  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ROT_LEFT    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ROT_RIGHT   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CLEAR       = 4'd8;
    localparam logic [MODE_W-1:0] MODE_READ_AT     = 4'd9;

    // Width of the status field.
    localparam int STATUS_W = 3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

endpackage

// File: hw/rtl/bounded_circular_deque.sv
// Bounded circular deque: ring store in RAM walked by a small sequencer, one entry per cycle in
// the search and shift loops. Push, clear, rotate by zero and every rejected request strobe o_done
// in the cycle after acceptance; reads, pops and removals at an index pass S_TAKE, a removal from
// the middle then shifts later entries down in S_SHIFT, removal by value first walks S_SRCH, and
// rotation by p runs S_ROT_RD and S_ROT_WR p times. A new item is accepted in the cycle that o_done
// strobes. The single RAM port pair sets the pace of the loops. Reset clears state, head, count and done only.
module bounded_circular_deque #(
    parameter int DEPTH      = bcdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bcdq_pkg::DATA_WIDTH_DEF,
    parameter int IW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bcdq_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [DATA_WIDTH-1:0]      i_value_in,
    input  logic [IW-1:0]                     i_position,
    output logic                              o_done,
    output logic [bcdq_pkg::STATUS_W-1:0]     o_status,
    output logic signed [DATA_WIDTH-1:0]      o_data_out,
    output logic [CW-1:0]                     o_count_out
);

    localparam int SW = CW + 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] LAST_OFF = CW'(DEPTH - 1);
    localparam logic [CW-1:0] ONE      = CW'(1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TAKE   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_SRCH   = 6'b001000,
        S_ROT_RD = 6'b010000,
        S_ROT_WR = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic [IW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_done, n_done;
    logic [bcdq_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [DATA_WIDTH-1:0]         r_val, n_val;
    logic [IW-1:0]                 r_pos, n_pos;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [bcdq_pkg::STATUS_W-1:0] r_status, n_status;
    logic [DATA_WIDTH-1:0]         r_data, n_data;

    logic                  we;
    logic [IW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    logic [CW-1:0] count_m1;
    logic [CW-1:0] idx_p1;
    logic [SW-1:0] idx_p2;
    logic [IW-1:0] tgt;
    logic          take;

    // Ring slot of a logical offset from the head; the sum stays below twice the depth.
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    bcdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Index arithmetic shared by the sequencer.
    assign count_m1 = r_count - ONE;
    assign idx_p1   = CW'(r_idx) + ONE;
    assign idx_p2   = SW'(r_idx) + SW'(2);

    // Logical index that a pop or indexed request works on.
    always_comb begin
        unique case (i_mode) inside
            bcdq_pkg::MODE_POP_BACK:  tgt = count_m1[IW-1:0];
            bcdq_pkg::MODE_POP_FRONT: tgt = '0;
            default:                  tgt = i_position;
        endcase
    end

    // Sequencer: request decode, then search, shift and rotate loops over the RAM.
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_done   = 1'b0;
        n_mode   = r_mode;
        n_val    = r_val;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_status = r_status;
        n_data   = r_data;
        we       = 1'b0;
        waddr    = slot(r_head, r_count);
        wdata    = i_value_in;
        raddr    = slot(r_head, CW'(r_idx));
        take     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_mode;
                    n_val    = i_value_in;
                    n_pos    = i_position;
                    n_data   = '0;
                    n_status = bcdq_pkg::ST_OK;
                    n_done   = 1'b1;
                    unique case (i_mode) inside
                        bcdq_pkg::MODE_PUSH_BACK, bcdq_pkg::MODE_PUSH_FRONT: begin
                            if (r_count == CNT_FULL) begin
                                n_status = bcdq_pkg::ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + ONE;
                                if (i_mode == bcdq_pkg::MODE_PUSH_FRONT) begin
                                    waddr  = slot(r_head, LAST_OFF);
                                    n_head = slot(r_head, LAST_OFF);
                                end
                            end
                        end
                        bcdq_pkg::MODE_POP_BACK, bcdq_pkg::MODE_POP_FRONT,
                        bcdq_pkg::MODE_REMOVE_AT, bcdq_pkg::MODE_READ_AT: begin
                            if (r_count == '0) begin
                                n_status = bcdq_pkg::ST_EMPTY;
                            end else if (CW'(tgt) >= r_count) begin
                                n_status = bcdq_pkg::ST_RANGE;
                            end else begin
                                n_done  = 1'b0;
                                n_idx   = tgt;
                                raddr   = slot(r_head, CW'(tgt));
                                n_state = S_TAKE;
                            end
                        end
                        bcdq_pkg::MODE_REMOVE_VAL: begin
                            if (r_count == '0) begin
                                n_status = bcdq_pkg::ST_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_idx   = '0;
                                raddr   = r_head;
                                n_state = S_SRCH;
                            end
                        end
                        bcdq_pkg::MODE_ROT_LEFT, bcdq_pkg::MODE_ROT_RIGHT: begin
                            if (r_count == '0) begin
                                n_status = bcdq_pkg::ST_EMPTY;
                            end else if (i_position != '0) begin
                                n_done  = 1'b0;
                                n_state = S_ROT_RD;
                            end
                        end
                        bcdq_pkg::MODE_CLEAR: begin
                            n_count = '0;
                            n_head  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Entry at the target index is on the read port.
            S_TAKE: begin
                if (r_mode == bcdq_pkg::MODE_READ_AT) begin
                    n_data   = rdata;
                    n_status = bcdq_pkg::ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    take = 1'b1;
                end
            end

            // One entry compared per cycle, the next one read meanwhile.
            S_SRCH: begin
                if (rdata == r_val) begin
                    take = 1'b1;
                end else if (idx_p1 < r_count) begin
                    n_idx = r_idx + IW'(1);
                    raddr = slot(r_head, idx_p1);
                end else begin
                    n_status = bcdq_pkg::ST_MISSING;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            // Close the gap: entry i+1 is on the read port and goes to slot i.
            S_SHIFT: begin
                we    = 1'b1;
                waddr = slot(r_head, CW'(r_idx));
                wdata = rdata;
                n_idx = r_idx + IW'(1);
                if (idx_p2 < SW'(r_count)) begin
                    raddr = slot(r_head, idx_p2[CW-1:0]);
                end else begin
                    n_count  = count_m1;
                    n_status = bcdq_pkg::ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            // Rotation step, read half: the front or the back entry.
            S_ROT_RD: begin
                if (r_mode == bcdq_pkg::MODE_ROT_LEFT) begin
                    raddr = r_head;
                end else begin
                    raddr = slot(r_head, count_m1);
                end
                n_state = S_ROT_WR;
            end

            // Rotation step, write half: copy the entry across and move the head.
            S_ROT_WR: begin
                we    = 1'b1;
                wdata = rdata;
                if (r_mode == bcdq_pkg::MODE_ROT_LEFT) begin
                    waddr  = slot(r_head, r_count);
                    n_head = slot(r_head, ONE);
                end else begin
                    waddr  = slot(r_head, LAST_OFF);
                    n_head = slot(r_head, LAST_OFF);
                end
                n_pos = r_pos - IW'(1);
                if (r_pos == IW'(1)) begin
                    n_status = bcdq_pkg::ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_ROT_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Removal of the entry at r_idx, whose value is on the read port.
        if (take) begin
            n_data   = rdata;
            n_status = bcdq_pkg::ST_OK;
            if (r_idx == '0) begin
                n_head  = slot(r_head, ONE);
                n_count = count_m1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end else if (idx_p1 < r_count) begin
                raddr   = slot(r_head, idx_p1);
                n_state = S_SHIFT;
            end else begin
                n_count = count_m1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Request and result registers.
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_data   <= n_data;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_data_out  = r_data;
    assign o_count_out = r_count;

endmodule

// File: hw/rtl/bcdq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module bcdq_ram #(
    parameter int WIDTH = bcdq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = bcdq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port; a read of the address being written returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
